// ===== rtl/bfts_pkg.sv =====
// ----------------------------------------------------------------------------
// bfts_pkg
// Shared types, constants and codes for the flow table with counters.
// ----------------------------------------------------------------------------
package bfts_pkg;

  localparam int unsigned FlowEntriesDefault = 1024;
  localparam int unsigned KeyW = 104;
  localparam int unsigned StatW = 32 + 48 + 16 + 16 + 52 + 52 + 128;

  localparam logic [7:0] ProtoTcp = 8'd6;
  localparam logic [7:0] FlagFin = 8'h01;
  localparam logic [7:0] FlagSyn = 8'h02;
  localparam logic [7:0] FlagRst = 8'h04;
  localparam logic [7:0] FlagAck = 8'h10;

  localparam logic [1:0] StatusHit = 2'd0;
  localparam logic [1:0] StatusNew = 2'd1;
  localparam logic [1:0] StatusFull = 2'd2;

  localparam logic [10:0] FlowLimitReset = 11'd1024;
  localparam logic [0:0] RegFlowLimit = 1'b0;

  typedef struct packed {
    logic [31:0] pkts;
    logic [47:0] bytes;
    logic [15:0] min_len;
    logic [15:0] max_len;
    logic [51:0] last_time;
    logic [51:0] gap_sum;
    logic [31:0] syn;
    logic [31:0] ack;
    logic [31:0] fin;
    logic [31:0] rst;
  } stats_t;

  // Controller to datapath.
  typedef struct packed {
    logic load_pkt;     // capture the input word
    logic clr_idx;      // restart the scan at entry zero
    logic step_idx;     // advance the scan index
    logic key_rd;       // read key at scan index
    logic stat_rd;      // compared key matched; note its direction
    logic create;       // write key and update fresh stats
    logic update;       // write updated stats
    logic mark_full;    // result is a table-full word
  } dp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic scan_done;    // scan index reached the entry count
    logic match;        // compared key matches the packet
    logic can_add;      // room for a new entry
  } dp_stat_t;

  function automatic logic [31:0] inc_sat32(input logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

endpackage

// ===== rtl/bfts_ram.sv =====
// ----------------------------------------------------------------------------
// bfts_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module bfts_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end

endmodule

// ===== rtl/bfts_datapath.sv =====
// ----------------------------------------------------------------------------
// bfts_datapath
// Packet register, key and statistics memories, scan counter and update math.
// ----------------------------------------------------------------------------
module bfts_datapath #(
  parameter int unsigned FlowEntries = bfts_pkg::FlowEntriesDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  bfts_pkg::dp_cmd_t   cmd_i,
  output bfts_pkg::dp_stat_t  stat_o,
  input  logic [10:0]         flow_limit_i,
  input  logic [31:0]         src_addr_i,
  input  logic [31:0]         dst_addr_i,
  input  logic [15:0]         src_port_num_i,
  input  logic [15:0]         dst_port_num_i,
  input  logic [7:0]          ip_proto_i,
  input  logic [15:0]         pkt_length_i,
  input  logic [51:0]         arrival_us_i,
  input  logic [7:0]          tcp_flag_bits_i,
  output logic [1:0]          lookup_status_o,
  output logic [9:0]          flow_slot_o,
  output logic                fwd_dir_o,
  output bfts_pkg::stats_t    stats_o
);

  localparam int unsigned AddrW = $clog2(FlowEntries);
  localparam int unsigned CntW = $clog2(FlowEntries + 1);
  localparam int unsigned KeyWLocal = bfts_pkg::KeyW;

  logic [31:0] sa_q, da_q;
  logic [15:0] sp_q, dp_q, len_q;
  logic [7:0]  pr_q, fl_q;
  logic [51:0] now_q;
  logic [CntW-1:0] idx_q, idx_d, cnt_q, cnt_d;
  logic [AddrW-1:0] slot_q;
  logic [AddrW-1:0] new_slot;
  logic [KeyWLocal-1:0] key_rd;
  bfts_pkg::stats_t st_rd, st_new, st_base, res_q;
  logic [1:0] status_q;
  logic fwd_q;
  logic fwd_hit_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_pkt) begin
      sa_q <= src_addr_i;  da_q <= dst_addr_i;
      sp_q <= src_port_num_i; dp_q <= dst_port_num_i;
      pr_q <= ip_proto_i;  len_q <= pkt_length_i;
      now_q <= arrival_us_i; fl_q <= tcp_flag_bits_i;
    end
  end

  always_comb begin
    idx_d = idx_q;
    if (cmd_i.clr_idx) begin
      idx_d = '0;
    end else if (cmd_i.step_idx) begin
      idx_d = idx_q + CntW'(1);
    end
    cnt_d = cnt_q;
    if (cmd_i.create) begin
      cnt_d = cnt_q + CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      cnt_q <= '0;
    end else begin
      idx_q <= idx_d;
      cnt_q <= cnt_d;
    end
  end

  // The key being compared belongs to the entry addressed in the cycle before.
  always_ff @(posedge clk_i) begin
    if (cmd_i.key_rd) begin
      slot_q <= idx_q[AddrW-1:0];
    end
  end

  // A new entry always goes to the first free slot.
  assign new_slot = cnt_q[AddrW-1:0];

  logic [31:0] k_sa, k_da;
  logic [15:0] k_sp, k_dp;
  logic [7:0]  k_pr;
  assign {k_sa, k_da, k_sp, k_dp, k_pr} = key_rd;

  logic [31:0] lim32;
  assign lim32 = (32'(flow_limit_i) < 32'(FlowEntries))
               ? 32'(flow_limit_i) : 32'(FlowEntries);

  assign stat_o.scan_done = (idx_q == cnt_q);
  assign stat_o.match = (k_pr == pr_q) &&
    ((k_sa == sa_q && k_da == da_q && k_sp == sp_q && k_dp == dp_q) ||
     (k_sa == da_q && k_da == sa_q && k_sp == dp_q && k_dp == sp_q));
  assign stat_o.can_add = 32'(cnt_q) < lim32;

  // The key memory moves on to the next entry after a match, so the
  // direction is taken from the matching key while it is still on hand.
  always_ff @(posedge clk_i) begin
    if (cmd_i.stat_rd) begin
      fwd_hit_q <= (k_sa == sa_q);
    end
  end

  logic [AddrW-1:0] key_addr, st_addr;
  logic key_we, st_we;
  assign key_we = cmd_i.create;
  assign key_addr = cmd_i.create ? new_slot : idx_q[AddrW-1:0];
  assign st_we = cmd_i.create || cmd_i.update;
  assign st_addr = cmd_i.create ? new_slot : slot_q;

  bfts_ram #(.Width(bfts_pkg::KeyW), .Depth(FlowEntries)) u_key_ram (
    .clk_i, .we_i(key_we), .addr_i(key_addr),
    .wdata_i({sa_q, da_q, sp_q, dp_q, pr_q}), .rdata_o(key_rd)
  );

  bfts_ram #(.Width(bfts_pkg::StatW), .Depth(FlowEntries)) u_stat_ram (
    .clk_i, .we_i(st_we), .addr_i(st_addr),
    .wdata_i(st_new), .rdata_o(st_rd)
  );

  // Fresh entries start from the initial counter values.
  logic [48:0] byte_sum;
  logic [52:0] gap_sum;
  logic [51:0] gap;
  logic tcp;

  always_comb begin
    if (cmd_i.create) begin
      st_base = '0;
      st_base.min_len = 16'hFFFF;
    end else begin
      st_base = st_rd;
    end
    tcp = (pr_q == bfts_pkg::ProtoTcp);
    st_new = st_base;
    st_new.pkts = bfts_pkg::inc_sat32(st_base.pkts);
    byte_sum = {1'b0, st_base.bytes} + 49'(len_q);
    st_new.bytes = byte_sum[48] ? '1 : byte_sum[47:0];
    if (len_q < st_base.min_len) st_new.min_len = len_q;
    if (len_q > st_base.max_len) st_new.max_len = len_q;
    gap = (now_q >= st_base.last_time) ? now_q - st_base.last_time : '0;
    gap_sum = {1'b0, st_base.gap_sum} + {1'b0, gap};
    if (st_base.last_time != '0) begin
      st_new.gap_sum = gap_sum[52] ? '1 : gap_sum[51:0];
    end
    st_new.last_time = now_q;
    if (tcp && (fl_q & bfts_pkg::FlagSyn) != '0) st_new.syn = bfts_pkg::inc_sat32(st_base.syn);
    if (tcp && (fl_q & bfts_pkg::FlagAck) != '0) st_new.ack = bfts_pkg::inc_sat32(st_base.ack);
    if (tcp && (fl_q & bfts_pkg::FlagFin) != '0) st_new.fin = bfts_pkg::inc_sat32(st_base.fin);
    if (tcp && (fl_q & bfts_pkg::FlagRst) != '0) st_new.rst = bfts_pkg::inc_sat32(st_base.rst);
  end

  // Result word.
  always_ff @(posedge clk_i) begin
    if (cmd_i.mark_full) begin
      res_q <= '0;
      status_q <= bfts_pkg::StatusFull;
      fwd_q <= 1'b0;
    end else if (st_we) begin
      res_q <= st_new;
      status_q <= cmd_i.create ? bfts_pkg::StatusNew : bfts_pkg::StatusHit;
      fwd_q <= cmd_i.create ? 1'b1 : fwd_hit_q;
    end
  end

  logic [9:0] slot_out_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.mark_full) begin
      slot_out_q <= '0;
    end else if (st_we) begin
      slot_out_q <= 10'(st_addr);
    end
  end

  assign lookup_status_o = status_q;
  assign flow_slot_o = slot_out_q;
  assign fwd_dir_o = fwd_q;
  assign stats_o = res_q;

endmodule

// ===== rtl/bfts_ctrl.sv =====
// ----------------------------------------------------------------------------
// bfts_ctrl
// Sequencer for one packet: scan, then create, update or mark the table full, then hand off.
// ----------------------------------------------------------------------------
module bfts_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output bfts_pkg::dp_cmd_t  cmd_o,
  input  bfts_pkg::dp_stat_t stat_i
);

  typedef enum logic [6:0] {
    StIdle  = 7'b0000001,
    StScan  = 7'b0000010,
    StCheck = 7'b0000100,
    StRead  = 7'b0001000,
    StWait  = 7'b0010000,
    StUpd   = 7'b0100000,
    StOut   = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic in_acc;

  // A finished word may sit in the output register while the next packet
  // is scanned; a new result is only written once that word is gone.
  assign in_stall_o = (state_q != StIdle);
  assign in_acc = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      StIdle: begin
        if (in_acc) begin
          cmd_o.load_pkt = 1'b1;
          cmd_o.clr_idx = 1'b1;
          state_d = StScan;
        end
      end
      StScan: begin
        if (stat_i.scan_done) begin
          state_d = StOut;
        end else begin
          cmd_o.key_rd = 1'b1;
          cmd_o.step_idx = 1'b1;
          state_d = StCheck;
        end
      end
      StCheck: begin
        if (stat_i.match) begin
          cmd_o.stat_rd = 1'b1;
          state_d = StRead;
        end else begin
          state_d = StScan;
        end
      end
      StRead: begin
        state_d = StWait;
      end
      StWait: begin
        state_d = StUpd;
      end
      StUpd: begin
        if (!out_valid_q) begin
          cmd_o.update = 1'b1;
          out_valid_d = 1'b1;
          state_d = StIdle;
        end
      end
      StOut: begin
        if (!out_valid_q) begin
          if (stat_i.can_add) cmd_o.create = 1'b1;
          else cmd_o.mark_full = 1'b1;
          out_valid_d = 1'b1;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== rtl/bidirectional_flow_table_stats.sv =====
// ----------------------------------------------------------------------------
// bidirectional_flow_table_stats
// Five-tuple flow table with per-flow saturating counters.
// ----------------------------------------------------------------------------
// Each accepted word is one packet header. The block scans the occupied
// entries in insertion order, through StScan and StCheck for each entry
// because every key comes from a single-port memory with a registered read,
// looking for the same protocol and 5-tuple in either direction. A hit then
// passes StRead, StWait and StUpd for the statistics read-modify-write;
// a miss goes through StScan, which sees the end of the scan, and StOut,
// which creates the entry or reports a full table. The next word is taken
// only in StIdle, once the last one is finished, and a finished word that
// the result side stalls holds back the writing of the next one. The result
// register keeps a finished word while the next packet is being scanned.
// The flow_limit register (address 0) caps how many flows are created; the
// lower of it and FlowEntries applies. There is no clearing pass after
// reset: only entries below the fill count are ever read.
// ----------------------------------------------------------------------------
module bidirectional_flow_table_stats #(
  parameter int unsigned FlowEntries = bfts_pkg::FlowEntriesDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] src_addr_i,
  input  logic [31:0] dst_addr_i,
  input  logic [15:0] src_port_num_i,
  input  logic [15:0] dst_port_num_i,
  input  logic [7:0]  ip_proto_i,
  input  logic [15:0] pkt_length_i,
  input  logic [51:0] arrival_us_i,
  input  logic [7:0]  tcp_flag_bits_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  lookup_status_o,
  output logic [9:0]  flow_slot_o,
  output logic        fwd_dir_o,
  output logic [31:0] packet_total_o,
  output logic [47:0] byte_total_o,
  output logic [15:0] min_length_o,
  output logic [15:0] max_length_o,
  output logic [51:0] gap_sum_us_o,
  output logic [31:0] syn_total_o,
  output logic [31:0] ack_total_o,
  output logic [31:0] fin_total_o,
  output logic [31:0] rst_total_o
);

  logic [10:0] flow_limit_q;
  bfts_pkg::dp_cmd_t cmd;
  bfts_pkg::dp_stat_t stat;
  bfts_pkg::stats_t stats;
  logic reg_sel;

  // The only register sits at byte address 0.
  assign reg_sel = (paddr[1:0] == 2'b00) && (1'(paddr >> 2) == bfts_pkg::RegFlowLimit);
  assign pready = 1'b1;
  assign prdata = reg_sel ? {21'd0, flow_limit_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flow_limit_q <= bfts_pkg::FlowLimitReset;
    end else if (psel && penable && pwrite && reg_sel) begin
      flow_limit_q <= pwdata[10:0];
    end
  end

  bfts_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
    .cmd_o(cmd), .stat_i(stat)
  );

  bfts_datapath #(.FlowEntries(FlowEntries)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .stat_o(stat), .flow_limit_i(flow_limit_q),
    .src_addr_i, .dst_addr_i, .src_port_num_i, .dst_port_num_i, .ip_proto_i,
    .pkt_length_i, .arrival_us_i, .tcp_flag_bits_i,
    .lookup_status_o, .flow_slot_o, .fwd_dir_o, .stats_o(stats)
  );

  assign packet_total_o = stats.pkts;
  assign byte_total_o = stats.bytes;
  assign min_length_o = stats.min_len;
  assign max_length_o = stats.max_len;
  assign gap_sum_us_o = stats.gap_sum;
  assign syn_total_o = stats.syn;
  assign ack_total_o = stats.ack;
  assign fin_total_o = stats.fin;
  assign rst_total_o = stats.rst;

endmodule

// ===== rtl/bfts_checker.sv =====
// ----------------------------------------------------------------------------
// bfts_checker
// Port-level checks on the flow table, bound to the top level.
// ----------------------------------------------------------------------------
module bfts_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [1:0] lookup_status_o,
  input logic [9:0] flow_slot_o,
  input logic       pready
);

  // A full-table word carries no slot.
  a_full_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && lookup_status_o == bfts_pkg::StatusFull |-> flow_slot_o == '0)
    else $error("full result with nonzero slot");

  // No status code beyond the three defined ones.
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> lookup_status_o != 2'd3)
    else $error("bad lookup status");

  // Acceptance is never back to back: the stall rises once a packet is taken.
  a_no_b2b: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("packet accepted while busy");

  // A stalled result stays put.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(lookup_status_o))
    else $error("stalled result changed");

  a_pready: assert property (@(posedge clk_i) pready)
    else $error("pready low");

endmodule

bind bidirectional_flow_table_stats bfts_checker u_bfts_checker (
  .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
  .lookup_status_o, .flow_slot_o, .pready
);
